// ===== rtl/cdf53_pkg.sv =====
// cdf53_pkg: shared types and constants of the 2-d cdf 5/3 wavelet block
// no dependencies
package cdf53_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 28;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int ACC_W      = 40;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'b1;

    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    typedef struct packed {
        logic signed [COEF_W-1:0] ll_coef;
        logic signed [COEF_W-1:0] hl_coef;
        logic signed [COEF_W-1:0] lh_coef;
        logic signed [COEF_W-1:0] hh_coef;
        logic [COL_W-1:0]         band_col;
        logic [ROW_W-1:0]         band_row;
        logic                     tile_done;
    } t_result;

    // one 5x5 neighbourhood of samples plus quad position
    typedef struct packed {
        logic signed [24:0][SAMPLE_W-1:0] win;
        logic [COL_W-1:0]                 band_col;
        logic [ROW_W-1:0]                 band_row;
        logic                             tile_done;
    } t_job;

    // saturate value*4 to the coefficient width
    function automatic logic signed [COEF_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W+1:0] s;
        s = {v, 2'b00};
        if (s > $signed({{(ACC_W+2-COEF_W){1'b0}}, {1'b0, {(COEF_W-1){1'b1}}}}))
            return {1'b0, {(COEF_W-1){1'b1}}};
        else if (s < $signed({{(ACC_W+2-COEF_W){1'b1}}, {1'b1, {(COEF_W-1){1'b0}}}}))
            return {1'b1, {(COEF_W-1){1'b0}}};
        else
            return s[COEF_W-1:0];
    endfunction

    // signed divide by four, rounding toward zero
    function automatic logic signed [ACC_W-1:0] div4(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ((v < 0) ? ACC_W'(3) : ACC_W'(0));
        return t >>> 2;
    endfunction

endpackage

// ===== rtl/cdf53_stream_if.sv =====
// cdf53_stream_if: valid/ready channel carrying a payload
// no dependencies
interface cdf53_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cdf53_nonseparable_dwt2d.sv =====
// non-separable 2-d cdf 5/3 wavelet, one level, on a raster sample stream.
// one sample is accepted per cycle; each 2x2 quad yields one word with the
// ll/hl/lh/hh coefficients (times 256, saturated to 28 bits) once the last sample
// of its 5x5 neighbourhood has passed the input, job, filter and output registers.
// the line store hands over one column of the four older rows per sample and
// the window comes from a short column history, so the rate is one sample per
// cycle; only a stalled output holds the input back, once the internal stages fill.
// writing either size register restarts the tile; the store needs no clearing.
// depends on cdf53_pkg, cdf53_stream_if, cdf53_front, cdf53_back
module cdf53_nonseparable_dwt2d #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_idx,
    input  logic [12:0]                  i_cfg_data,
    cdf53_stream_if.sink                 s_in,
    cdf53_stream_if.source               m_out
);
    import cdf53_pkg::*;

    logic [8:0]  r_tile_width;
    logic [12:0] r_tile_height;
    logic [8:0]  w_eff;
    logic [12:0] h_eff;
    logic        restart;
    logic        job_valid, job_ready;
    t_job        job;
    t_result     res;

    // effective sizes: even, clamped to the supported range
    always_comb begin
        w_eff = {r_tile_width[8:1], 1'b0};
        if (w_eff < 9'd4) w_eff = 9'd4;
        if (32'(w_eff) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH & ~1);
        h_eff = {r_tile_height[12:1], 1'b0};
        if (h_eff < 13'd4) h_eff = 13'd4;
        if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
    end

    assign restart = i_cfg_we && (i_cfg_idx == REG_TILE_WIDTH || i_cfg_idx == REG_TILE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width  <= 9'd256;
            r_tile_height <= 13'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TILE_WIDTH:  r_tile_width  <= i_cfg_data[8:0];
                REG_TILE_HEIGHT: r_tile_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cdf53_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_restart(restart), .i_w(w_eff), .i_h(h_eff),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_sample(s_in.data),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    cdf53_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_result(res)
    );

    assign m_out.data = res;
endmodule

// ===== rtl/cdf53_front.sv =====
// cdf53_front: line store, position tracking, 5x5 window gather
// depends on cdf53_pkg
module cdf53_front #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_restart,
    input  logic [8:0]                            i_w,
    input  logic [12:0]                           i_h,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [cdf53_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                  o_job_valid,
    input  logic                                  i_job_ready,
    output cdf53_pkg::t_job                       o_job
);
    import cdf53_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // line store: per column, the four rows above the current one (nearest first)
    logic [3:0][SAMPLE_W-1:0]   r_lines [MAX_WIDTH];
    logic [3:0][SAMPLE_W-1:0]   r_rd;
    // columns seen before the current one, nearest first
    logic [4:0][SAMPLE_W-1:0]   r_hist [4];
    logic [4:0][SAMPLE_W-1:0]   cur_col;
    logic [12:0]                r_row;
    logic [CW:0]                r_col;
    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic [CW-1:0]              r_a_addr;
    logic                       r_a_emit, r_a_rfirst, r_a_rlast, r_a_cfirst, r_a_clast;
    logic [COL_W-1:0]           r_a_bcol;
    logic [ROW_W-1:0]           r_a_brow;
    logic                       r_a_done;
    logic                       r_job_valid;
    t_job                       r_job;
    logic                       acc, b_adv;
    logic [12:0]                n_row;
    logic [CW:0]                n_col;
    logic                       qy_ok, qx_ok, last_r, last_c;
    logic [12:0]                qy;
    logic [CW:0]                qx;
    t_job                       n_job;

    assign b_adv       = !r_a_valid || !r_a_emit || !r_job_valid || i_job_ready;
    assign o_ready     = b_adv;
    assign acc         = i_valid && b_adv;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    assign last_r = (r_row == i_h - 13'd1);
    assign last_c = (r_col == (CW+1)'(i_w) - (CW+1)'(1));
    assign qy_ok  = last_r || (!r_row[0] && r_row >= 13'd2 && r_row <= i_h - 13'd2);
    assign qx_ok  = last_c || (!r_col[0] && r_col >= (CW+1)'(2)
                               && r_col <= (CW+1)'(i_w) - (CW+1)'(2));
    assign qy = last_r ? (i_h >> 1) - 13'd1 : (r_row >> 1) - 13'd1;
    assign qx = last_c ? ((CW+1)'(i_w) >> 1) - (CW+1)'(1) : (r_col >> 1) - (CW+1)'(1);

    // current column: new sample plus the four rows above it
    assign cur_col = {r_rd, r_a_sample};

    // distance back (rows or columns) of window tap p (0..4 for -2..+2)
    // first quad reflects to 2,1,0,1,2; the last one ends on 0,1,2,3,2 of the tail
    function automatic logic [2:0] tap_off(input int p, input logic first, input logic last);
        logic [2:0] o;
        o = 3'(4 - p);
        if (last) begin
            o = (p == 4) ? 3'd1 : 3'(3 - p);
        end else if (first) begin
            o = (p <= 2) ? 3'(p) : 3'(4 - p);
        end
        return o;
    endfunction

    always_comb begin
        logic [2:0]               ro, co;
        logic [4:0][SAMPLE_W-1:0] colv;
        n_job = '0;
        for (int a = 0; a < 5; a++)
            for (int b = 0; b < 5; b++) begin
                ro = tap_off(a, r_a_rfirst, r_a_rlast);
                co = tap_off(b, r_a_cfirst, r_a_clast);
                colv = (co == 3'd0) ? cur_col : r_hist[2'(co - 3'd1)];
                n_job.win[a*5+b] = colv[ro];
            end
        n_job.band_col  = r_a_bcol;
        n_job.band_row  = r_a_brow;
        n_job.tile_done = r_a_done;
    end

    always_comb begin
        n_col = r_col + (CW+1)'(1);
        n_row = r_row;
        if (n_col >= (CW+1)'(i_w)) begin
            n_col = '0;
            n_row = (r_row + 13'd1 >= i_h) ? 13'd0 : r_row + 13'd1;
        end
    end

    // line store: read at the accepted column, write back the shifted column as the sample moves on
    always_ff @(posedge i_clk) begin
        if (acc) r_rd <= r_lines[r_col[CW-1:0]];
        if (b_adv && r_a_valid) r_lines[r_a_addr] <= cur_col[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_sample <= i_sample;
            r_a_addr   <= r_col[CW-1:0];
            r_a_emit   <= qy_ok && qx_ok;
            r_a_rfirst <= (r_row == 13'd2);
            r_a_rlast  <= last_r;
            r_a_cfirst <= (r_col == (CW+1)'(2));
            r_a_clast  <= last_c;
            r_a_bcol   <= COL_W'(qx);
            r_a_brow   <= ROW_W'(qy);
            r_a_done   <= last_r && last_c;
        end
        if (b_adv && r_a_valid) begin
            r_hist[0] <= cur_col;
            for (int k = 1; k < 4; k++) r_hist[k] <= r_hist[k-1];
            if (r_a_emit) r_job <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_a_valid   <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (b_adv) r_a_valid <= i_valid;
            r_job_valid <= (r_job_valid && !i_job_ready) || (b_adv && r_a_valid && r_a_emit);
            if (i_restart) begin
                r_row <= '0;
                r_col <= '0;
            end else if (acc) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end
endmodule

// ===== rtl/cdf53_back.sv =====
// cdf53_back: two-stage filter datapath whose second stage is the output register
// depends on cdf53_pkg
module cdf53_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  cdf53_pkg::t_job    i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output cdf53_pkg::t_result o_result
);
    import cdf53_pkg::*;

    logic                    r_v1, r_v2;
    logic signed [ACC_W-1:0] r_ll, r_hl, r_lh, r_hh;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic                    r_done;
    t_result                 r_out;
    logic                    adv2, adv1;
    logic signed [ACC_W-1:0] n_ll, n_hl, n_lh, n_hh, lh2, ll2, hl2;

    assign adv2        = !r_v2 || i_ready;
    assign adv1        = !r_v1 || adv2;
    assign o_job_ready = adv1;
    assign o_valid     = r_v2;
    assign o_result    = r_out;

    function automatic logic signed [ACC_W-1:0] s(input int k);
        return ACC_W'($signed(i_job.win[k]));
    endfunction

    // window index: row a (-2..+2 as 0..4), column b likewise
    always_comb begin
        logic signed [ACC_W-1:0] aMM, bMM, aM0, bM0, aMP, cMM, dMM, cM0, dM0, cMP;
        logic signed [ACC_W-1:0] a0M, b0M, a00, b00, a0P, c0M, d0M, c00, d00, c0P;
        logic signed [ACC_W-1:0] aPM, bPM, aP0, bP0, aPP;
        aMM = s(0);  bMM = s(1);  aM0 = s(2);  bM0 = s(3);  aMP = s(4);
        cMM = s(5);  dMM = s(6);  cM0 = s(7);  dM0 = s(8);  cMP = s(9);
        a0M = s(10); b0M = s(11); a00 = s(12); b00 = s(13); a0P = s(14);
        c0M = s(15); d0M = s(16); c00 = s(17); d00 = s(18); c0P = s(19);
        aPM = s(20); bPM = s(21); aP0 = s(22); bP0 = s(23); aPP = s(24);
        n_ll = 49*a00 - 7*(aM0+a0M) + aMM + 14*(b0M+cM0) - 2*(bMM+cMM) + 4*dMM;
        n_hl = -28*(a0P+a00) + 4*(aMP+aM0) + 56*b00 - 8*(cM0+cMP+bM0) + 16*dM0;
        n_lh = -28*(aP0+a00) + 4*(aPM+a0M) - 8*(b0M+bPM+c0M) + 56*c00 + 16*d0M;
        n_hh = 16*(aPP+a0P+aP0+a00) - 32*(b00+bP0+c00+c0P) + 64*d00;
    end

    // lifting updates in order
    assign lh2 = r_lh + div4(r_hh);
    assign ll2 = r_ll + div4(r_hl + lh2);
    assign hl2 = r_hl + div4(r_hh);

    always_ff @(posedge i_clk) begin
        if (adv1 && i_job_valid) begin
            r_ll <= n_ll; r_hl <= n_hl; r_lh <= n_lh; r_hh <= n_hh;
            r_col <= i_job.band_col; r_row <= i_job.band_row; r_done <= i_job.tile_done;
        end
        if (adv2 && r_v1) begin
            r_out.ll_coef   <= sat_out(ll2);
            r_out.hl_coef   <= sat_out(hl2);
            r_out.lh_coef   <= sat_out(lh2);
            r_out.hh_coef   <= sat_out(r_hh);
            r_out.band_col  <= r_col;
            r_out.band_row  <= r_row;
            r_out.tile_done <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_job_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end
endmodule

// ===== rtl/cdf53_checker.sv =====
// cdf53_checker: port-level assertions for the wavelet top level
// depends on cdf53_nonseparable_dwt2d ports
module cdf53_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready) else $error("input stalled with empty output");
    a_no_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid |-> !$isunknown(in_ready)) else $error("input ready unknown");
endmodule

bind cdf53_nonseparable_dwt2d cdf53_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready)
);
